// ===== src/chd_pkg.sv =====
package chd_pkg;

    localparam int TOTAL_BITS = 24;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
    localparam int HEX_BITS = 4;
    localparam int TRAILER_LEN = 2;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HI = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;

    typedef struct packed {
        logic [7:0]            data_byte;
        logic                  is_payload;
        logic                  is_final;
        logic [TOTAL_BITS-1:0] decoded_total;
        logic                  size_overflow;
    } result_t;

    typedef struct packed {
        logic               ok;
        logic [HEX_BITS-1:0] value;
    } hex_t;

endpackage

// ===== src/chd_channels.sv =====
interface chd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] body_byte;
    logic       end_of_body;

    modport source (output valid, output body_byte, output end_of_body, input ready);
    modport sink (input valid, input body_byte, input end_of_body, output ready);
endinterface

interface chd_out_if;
    logic                          valid;
    logic                          ready;
    logic [7:0]                    data_byte;
    logic                          is_payload;
    logic                          is_final;
    logic [chd_pkg::TOTAL_BITS-1:0] decoded_total;
    logic                          size_overflow;

    modport source (output valid, output data_byte, output is_payload, output is_final,
                    output decoded_total, output size_overflow, input ready);
    modport sink (input valid, input data_byte, input is_payload, input is_final,
                  input decoded_total, input size_overflow, output ready);
endinterface

// ===== src/chd_front.sv =====
module chd_front #(
    parameter int SIZE_BITS = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    chd_in_if.sink           body,
    output logic             push_valid,
    output chd_pkg::result_t push_item,
    input  logic             push_full
);
    import chd_pkg::*;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SIGNED,
        PH_DIGITS,
        PH_TAIL,
        PH_DATA,
        PH_TRAILER,
        PH_DONE
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [SIZE_BITS-1:0]  acc_reg, acc_next;
    logic [SIZE_BITS-1:0]  rem_reg, rem_next;
    logic [TOTAL_BITS-1:0] cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;
    logic                  zero_reg, zero_next;
    logic                  cr_reg, cr_next;
    logic                  ovf_reg, ovf_next;

    logic       take;
    logic       payload;
    logic       add_en;
    logic       blank;
    logic [7:0] c;
    hex_t       hv;

    function automatic hex_t hex_decode(input logic [7:0] ch);
        hex_t h;
        h.ok = 1'b1;
        h.value = '0;
        if (ch >= CH_0 && ch <= CH_9)
        begin
            h.value = HEX_BITS'(ch - CH_0);
        end
        else if (ch >= CH_LA && ch <= CH_LF_HI)
        begin
            h.value = HEX_BITS'(ch - CH_LA + 8'd10);
        end
        else if (ch >= CH_UA && ch <= CH_UF)
        begin
            h.value = HEX_BITS'(ch - CH_UA + 8'd10);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    assign c          = body.body_byte;
    assign body.ready = !push_full;
    assign take       = body.valid && body.ready;
    assign hv         = hex_decode(c);
    assign blank      = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT)
                     || (c == CH_FF) || (c == CH_CR);

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        cr_next    = cr_reg;
        ovf_next   = ovf_reg;
        payload    = 1'b0;
        add_en     = 1'b0;

        if (take)
        begin
            case (phase_reg)
                PH_LEAD, PH_SIGNED, PH_DIGITS, PH_TAIL:
                begin
                    if (cr_reg && c == CH_LF)
                    begin
                        if (neg_reg || acc_reg == '0)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            rem_next   = acc_reg;
                            phase_next = PH_DATA;
                        end
                        neg_next  = 1'b0;
                        zero_next = 1'b0;
                        cr_next   = 1'b0;
                    end
                    else
                    begin
                        if (phase_reg == PH_TAIL)
                        begin
                        end
                        else if (phase_reg == PH_LEAD && blank)
                        begin
                        end
                        else if (phase_reg == PH_LEAD && (c == CH_PLUS || c == CH_MINUS))
                        begin
                            neg_next   = neg_reg | (c == CH_MINUS);
                            phase_next = PH_SIGNED;
                        end
                        else if (phase_reg == PH_LEAD || phase_reg == PH_SIGNED)
                        begin
                            if (!hv.ok)
                            begin
                                phase_next = PH_TAIL;
                            end
                            else
                            begin
                                add_en     = 1'b1;
                                zero_next  = zero_reg | (hv.value == '0);
                                phase_next = PH_DIGITS;
                            end
                        end
                        else
                        begin
                            zero_next = 1'b0;
                            if (zero_reg && (c == CH_LX || c == CH_UX))
                            begin
                            end
                            else if (!hv.ok)
                            begin
                                phase_next = PH_TAIL;
                            end
                            else
                            begin
                                add_en = 1'b1;
                            end
                        end
                        cr_next = (c == CH_CR);
                    end
                end
                PH_DATA:
                begin
                    payload = 1'b1;
                    if (cnt_reg != TOTAL_MAX)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (rem_reg <= SIZE_BITS'(1))
                    begin
                        rem_next   = SIZE_BITS'(TRAILER_LEN);
                        phase_next = PH_TRAILER;
                    end
                    else
                    begin
                        rem_next = rem_reg - 1'b1;
                    end
                end
                PH_TRAILER:
                begin
                    if (rem_reg <= SIZE_BITS'(1))
                    begin
                        phase_next = PH_LEAD;
                        acc_next   = '0;
                        rem_next   = '0;
                        neg_next   = 1'b0;
                        zero_next  = 1'b0;
                        cr_next    = 1'b0;
                    end
                    else
                    begin
                        rem_next = rem_reg - 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end

        if (add_en)
        begin
            if (|acc_reg[SIZE_BITS-1 -: HEX_BITS])
            begin
                acc_next = '1;
                ovf_next = 1'b1;
            end
            else
            begin
                acc_next = {acc_reg[SIZE_BITS-HEX_BITS-1:0], hv.value};
            end
        end

        push_valid              = take && (payload || body.end_of_body);
        push_item.data_byte     = payload ? c : 8'd0;
        push_item.is_payload    = payload;
        push_item.is_final      = body.end_of_body;
        push_item.decoded_total = cnt_next;
        push_item.size_overflow = ovf_next;

        if (take && body.end_of_body)
        begin
            phase_next = PH_LEAD;
            acc_next   = '0;
            rem_next   = '0;
            cnt_next   = '0;
            neg_next   = 1'b0;
            zero_next  = 1'b0;
            cr_next    = 1'b0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            acc_reg   <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            neg_reg   <= 1'b0;
            zero_reg  <= 1'b0;
            cr_reg    <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
            neg_reg   <= neg_next;
            zero_reg  <= zero_next;
            cr_reg    <= cr_next;
            ovf_reg   <= ovf_next;
        end
    end

    a_data_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> rem_reg != '0)
        else $error("data phase with no bytes left");

    a_trailer_len: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_TRAILER |-> (rem_reg == SIZE_BITS'(1) || rem_reg == SIZE_BITS'(2)))
        else $error("trailer count out of range");

    a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
        take && body.end_of_body |=> phase_reg == PH_LEAD && cnt_reg == '0 && !ovf_reg)
        else $error("state not cleared after final word");

endmodule

// ===== src/chd_queue.sv =====
module chd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  chd_pkg::result_t push_item,
    output logic             push_full,
    chd_out_if.source        decoded
);
    import chd_pkg::*;

    localparam int DEPTH = 2;

    result_t    entry_reg [DEPTH];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] count_reg;
    logic       pop;
    result_t    head;

    assign push_full             = (count_reg == 2'(DEPTH));
    assign head                  = entry_reg[rd_reg];
    assign decoded.valid         = (count_reg != 2'd0);
    assign decoded.data_byte     = head.data_byte;
    assign decoded.is_payload    = head.is_payload;
    assign decoded.is_final      = head.is_final;
    assign decoded.decoded_total = head.decoded_total;
    assign decoded.size_overflow = head.size_overflow;
    assign pop                   = decoded.valid && decoded.ready;

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            entry_reg[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push_valid)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            count_reg <= count_reg + 2'(push_valid) - 2'(pop);
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> count_reg != 2'(DEPTH))
        else $error("push into full queue");

    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) == (wr_reg != rd_reg))
        else $error("queue pointers disagree with count");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(DEPTH))
        else $error("queue count out of range");

endmodule

// ===== src/http_chunked_body_decoder.sv =====
// Strips HTTP chunked framing from a body stream, one byte word per clock while the result queue
// is not full. Each chunk size is parsed like strtol in base 16 (blanks, sign, optional 0x, hex
// digits), the line is skipped to CR LF, size bytes are passed as payload and the two trailing
// bytes are dropped; a size of zero or less ends decoding until end_of_body. A result word is
// registered into the result queue for every payload byte and for the final byte of the body as
// the byte is taken. Sustained rate is one byte per cycle; a two-entry result queue lets input
// continue while a result waits on the output side, and input stalls only when that queue is full.
module http_chunked_body_decoder #(
    parameter int SIZE_BITS = 24
) (
    input  logic      clk,
    input  logic      rst_n,
    chd_in_if.sink    body,
    chd_out_if.source decoded
);
    import chd_pkg::*;

    logic    push_valid;
    logic    push_full;
    result_t push_item;

    chd_front #(
        .SIZE_BITS (SIZE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .body       (body),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_full  (push_full)
    );

    chd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_full  (push_full),
        .decoded    (decoded)
    );

endmodule

// ===== test/chunk_decode_scoreboard.sv =====
`timescale 1ns / 1ps
module chunk_decode_scoreboard #(
    parameter int SIZE_BITS = 24
) (
    input  logic clk,
    input  logic rst_n,
    chd_in_if    body_mon,
    chd_out_if   decoded_mon,
    output int   mismatch_count,
    output int   results_pending,
    output int   payload_words,
    output int   bodies_closed,
    output int   oversize_bodies
);
    import chd_pkg::*;

    localparam longint unsigned SIZE_LIMIT = (64'd1 << SIZE_BITS) - 64'd1;

    typedef enum logic [2:0] {
        SCAN_LEAD,
        SCAN_SIGN,
        SCAN_DIGITS,
        SCAN_TAIL,
        COPY_DATA,
        SKIP_TRAILER,
        BODY_DONE
    } scan_phase_t;

    scan_phase_t           phase;
    longint unsigned       size_acc;
    longint unsigned       remaining;
    logic [TOTAL_BITS-1:0] total;
    logic                  neg_size;
    logic                  lone_zero;
    logic                  cr_seen;
    logic                  oversize;
    result_t               expected_q[$];
    int                    errors;
    int                    payload_n;
    int                    finals_n;
    int                    oversize_n;

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF
            || c == CH_CR;
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
            return int'(c - CH_0);
        if (c >= CH_LA && c <= CH_LF_HI)
            return int'(c - CH_LA) + 10;
        if (c >= CH_UA && c <= CH_UF)
            return int'(c - CH_UA) + 10;
        return -1;
    endfunction

    task automatic new_chunk();
        phase     = SCAN_LEAD;
        size_acc  = 0;
        remaining = 0;
        neg_size  = 1'b0;
        lone_zero = 1'b0;
        cr_seen   = 1'b0;
    endtask

    task automatic reset_decoder();
        new_chunk();
        total    = '0;
        oversize = 1'b0;
    endtask

    task automatic add_digit(input int d);
        if (size_acc > ((SIZE_LIMIT - longint'(d)) >> HEX_BITS))
        begin
            size_acc = SIZE_LIMIT;
            oversize = 1'b1;
        end
        else
        begin
            size_acc = (size_acc << HEX_BITS) + longint'(d);
        end
    endtask

    task automatic scan_size_char(input logic [7:0] c);
        int d;
        d = hex_digit(c);
        if (phase == SCAN_LEAD)
        begin
            if (is_blank(c))
                return;
            if (c == CH_PLUS || c == CH_MINUS)
            begin
                if (c == CH_MINUS)
                    neg_size = 1'b1;
                phase = SCAN_SIGN;
                return;
            end
        end
        if (phase == SCAN_LEAD || phase == SCAN_SIGN)
        begin
            if (d < 0)
            begin
                phase = SCAN_TAIL;
                return;
            end
            add_digit(d);
            if (d == 0)
                lone_zero = 1'b1;
            phase = SCAN_DIGITS;
            return;
        end
        if (lone_zero && (c == CH_LX || c == CH_UX))
        begin
            lone_zero = 1'b0;
            return;
        end
        lone_zero = 1'b0;
        if (d < 0)
        begin
            phase = SCAN_TAIL;
            return;
        end
        add_digit(d);
    endtask

    task automatic close_size_line();
        if (neg_size || size_acc == 0)
        begin
            phase = BODY_DONE;
        end
        else
        begin
            remaining = size_acc;
            phase     = COPY_DATA;
        end
        neg_size  = 1'b0;
        lone_zero = 1'b0;
        cr_seen   = 1'b0;
    endtask

    task automatic decode_byte(input logic [7:0] c, input logic last);
        result_t r;
        logic    payload;
        payload = 1'b0;
        case (phase)
            SCAN_LEAD, SCAN_SIGN, SCAN_DIGITS, SCAN_TAIL:
            begin
                if (cr_seen && c == CH_LF)
                begin
                    close_size_line();
                end
                else
                begin
                    if (phase != SCAN_TAIL)
                        scan_size_char(c);
                    cr_seen = (c == CH_CR);
                end
            end
            COPY_DATA:
            begin
                payload = 1'b1;
                if (total != TOTAL_MAX)
                    total++;
                if (remaining != 0)
                    remaining--;
                if (remaining == 0)
                begin
                    remaining = TRAILER_LEN;
                    phase     = SKIP_TRAILER;
                end
            end
            SKIP_TRAILER:
            begin
                if (remaining != 0)
                    remaining--;
                if (remaining == 0)
                    new_chunk();
            end
            default:
            begin
                phase = BODY_DONE;
            end
        endcase

        if (payload || last)
        begin
            r.data_byte     = payload ? c : 8'h00;
            r.is_payload    = payload;
            r.is_final      = last;
            r.decoded_total = total;
            r.size_overflow = oversize;
            expected_q.push_back(r);
            if (payload)
                payload_n++;
            if (last)
            begin
                finals_n++;
                if (oversize)
                    oversize_n++;
            end
        end
        if (last)
            reset_decoder();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (expected_q.size() == 0)
        begin
            $display("%0t: result word with nothing pending: expected none, actual %h",
                     $time, got);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        check_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
        check_field("is_payload", 32'(want.is_payload), 32'(got.is_payload));
        check_field("is_final", 32'(want.is_final), 32'(got.is_final));
        check_field("decoded_total", 32'(want.decoded_total), 32'(got.decoded_total));
        check_field("size_overflow", 32'(want.size_overflow), 32'(got.size_overflow));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_decoder();
            expected_q.delete();
            errors     = 0;
            payload_n  = 0;
            finals_n   = 0;
            oversize_n = 0;
        end
        else
        begin
            if (decoded_mon.valid === 1'b1 && decoded_mon.ready === 1'b1)
                check_result(result_t'({decoded_mon.data_byte, decoded_mon.is_payload,
                                        decoded_mon.is_final, decoded_mon.decoded_total,
                                        decoded_mon.size_overflow}));
            if (body_mon.valid === 1'b1 && body_mon.ready === 1'b1)
                decode_byte(body_mon.body_byte, body_mon.end_of_body);
        end
        mismatch_count  <= errors;
        results_pending <= expected_q.size();
        payload_words   <= payload_n;
        bodies_closed   <= finals_n;
        oversize_bodies <= oversize_n;
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import chd_pkg::*;

    localparam int SIZE_BITS    = 24;
    localparam int ITEM_TARGET  = 1850;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    typedef enum int {
        BODY_CLEAN,
        BODY_CUT,
        BODY_NEGATIVE,
        BODY_EARLY_EOL,
        BODY_BARE_PREFIX,
        BODY_OVERSIZE,
        BODY_NOISE
    } body_kind_t;

    typedef struct packed {
        logic [7:0] value;
        logic       eob;
    } body_word_t;

    logic       clk;
    logic       rst_n;
    body_word_t body_words[$];
    bit         calm = 1'b0;
    bit         paused = 1'b0;
    int         words_sent = 0;
    int         cycles = 0;
    int         mismatch_count;
    int         results_pending;
    int         payload_words;
    int         bodies_closed;
    int         oversize_bodies;
    body_kind_t kind;
    int         pick;

    chd_in_if  body_ch();
    chd_out_if decoded_ch();

    http_chunked_body_decoder #(
        .SIZE_BITS(SIZE_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .body(body_ch),
        .decoded(decoded_ch)
    );

    chunk_decode_scoreboard #(
        .SIZE_BITS(SIZE_BITS)
    ) decode_sb (
        .clk(clk),
        .rst_n(rst_n),
        .body_mon(body_ch),
        .decoded_mon(decoded_ch),
        .mismatch_count(mismatch_count),
        .results_pending(results_pending),
        .payload_words(payload_words),
        .bodies_closed(bodies_closed),
        .oversize_bodies(oversize_bodies)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        decoded_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                decoded_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            decoded_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    function automatic logic [7:0] hex_char(input int d, input bit upper);
        if (d < 10)
            return CH_0 + 8'(d);
        return (upper ? CH_UA : CH_LA) + 8'(d - 10);
    endfunction

    task automatic push_byte(input logic [7:0] b);
        body_words.push_back({b, 1'b0});
    endtask

    task automatic push_blank();
        case ($urandom_range(0, 3))
            0: push_byte(CH_SPACE);
            1: push_byte(CH_TAB);
            2: push_byte(CH_VT);
            default: push_byte(CH_FF);
        endcase
    endtask

    task automatic push_hex(input longint unsigned value, input int min_digits);
        int n;
        int i;
        n = 1;
        while (n < 16 && (value >> (HEX_BITS * n)) != 0)
            n++;
        if (n < min_digits)
            n = min_digits;
        for (i = n - 1; i >= 0; i--)
            push_byte(hex_char(int'((value >> (HEX_BITS * i)) & 64'hF),
                               1'($urandom_range(0, 1))));
    endtask

    task automatic push_size_line(input longint unsigned size);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) push_blank();
        if ($urandom_range(0, 7) == 0)
            push_byte(CH_PLUS);
        if ($urandom_range(0, 5) == 0)
        begin
            push_byte(CH_0);
            push_byte($urandom_range(0, 1) ? CH_LX : CH_UX);
            push_hex(size, 1);
        end
        else
        begin
            push_hex(size, ($urandom_range(0, 4) == 0) ? $urandom_range(2, 4) : 1);
        end
        if ($urandom_range(0, 5) == 0)
        begin
            push_byte(CH_SEMI);
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(8'h61, 8'h7A)));
        end
        push_byte(CH_CR);
        push_byte(CH_LF);
    endtask

    task automatic push_chunk(input int size);
        push_size_line(64'(size));
        repeat (size) push_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) == 0)
        begin
            push_byte(8'($urandom_range(0, 255)));
            push_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            push_byte(CH_CR);
            push_byte(CH_LF);
        end
    endtask

    task automatic close_body(input int filler_max);
        repeat ($urandom_range(0, filler_max)) push_byte(8'($urandom_range(0, 255)));
        if (body_words.size() == 0)
            push_byte(8'($urandom_range(0, 255)));
        body_words[body_words.size() - 1].eob = 1'b1;
    endtask

    task automatic build_body(input body_kind_t what);
        int keep;
        body_words.delete();
        if (what != BODY_CLEAN && what != BODY_CUT && what != BODY_NOISE
            && $urandom_range(0, 1) == 1)
            push_chunk($urandom_range(1, 12));
        case (what)
            BODY_CLEAN, BODY_CUT:
            begin
                repeat ($urandom_range(1, 3))
                    push_chunk(($urandom_range(0, 15) == 0) ? $urandom_range(21, 160)
                                                            : $urandom_range(1, 20));
                push_size_line(0);
                if ($urandom_range(0, 1) == 1)
                begin
                    push_byte(CH_CR);
                    push_byte(CH_LF);
                end
                close_body(2);
                if (what == BODY_CUT)
                begin
                    keep = $urandom_range(1, body_words.size());
                    while (body_words.size() > keep)
                        void'(body_words.pop_back());
                    body_words[keep - 1].eob = 1'b1;
                end
            end
            BODY_NEGATIVE:
            begin
                if ($urandom_range(0, 2) == 0)
                    push_blank();
                push_byte(CH_MINUS);
                push_hex(64'($urandom_range(0, 40)), 1);
                push_byte(CH_CR);
                push_byte(CH_LF);
                close_body(4);
            end
            BODY_EARLY_EOL:
            begin
                if ($urandom_range(0, 1) == 1)
                    push_blank();
                if ($urandom_range(0, 2) == 0)
                    push_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                push_byte(CH_CR);
                push_byte(CH_LF);
                close_body(4);
            end
            BODY_BARE_PREFIX:
            begin
                push_byte(CH_0);
                push_byte($urandom_range(0, 1) ? CH_LX : CH_UX);
                case ($urandom_range(0, 2))
                    0: push_byte(CH_SEMI);
                    1: push_byte(CH_SPACE);
                    default: push_byte(8'($urandom_range(8'h67, 8'h77)));
                endcase
                push_byte(CH_CR);
                push_byte(CH_LF);
                close_body(4);
            end
            BODY_OVERSIZE:
            begin
                case ($urandom_range(0, 2))
                    0: push_size_line(64'hFFFFFF);
                    1: push_size_line(64'h1000000 + 64'($urandom_range(0, 24'hFFFFF)));
                    default: push_size_line(64'hFFFFFFFFF);
                endcase
                repeat ($urandom_range(1, 20)) push_byte(8'($urandom_range(0, 255)));
                close_body(0);
            end
            default:
            begin
                repeat ($urandom_range(1, 30)) push_byte(8'($urandom_range(0, 255)));
                close_body(0);
            end
        endcase
    endtask

    task automatic send_word(input body_word_t w);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            body_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        body_ch.valid       <= 1'b1;
        body_ch.body_byte   <= w.value;
        body_ch.end_of_body <= w.eob;
        do
            @(posedge clk);
        while (body_ch.ready !== 1'b1);
        words_sent++;
    endtask

    task automatic send_body();
        foreach (body_words[i])
            send_word(body_words[i]);
    endtask

    task automatic wait_drained();
        body_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (results_pending != 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        body_ch.valid       <= 1'b0;
        body_ch.body_byte   <= 8'h00;
        body_ch.end_of_body <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // two-byte chunk with extreme data, then a negative size
        body_words.delete();
        push_byte(CH_0 + 8'd2);
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_byte(CH_MINUS);
        push_byte(CH_0 + 8'd1);
        push_byte(CH_CR);
        push_byte(CH_LF);
        close_body(0);
        send_body();

        // empty size line
        body_words.delete();
        push_byte(CH_CR);
        push_byte(CH_LF);
        close_body(0);
        send_body();

        // prefix with no digits
        body_words.delete();
        push_byte(CH_0);
        push_byte(CH_LX);
        push_byte(CH_LA + 8'd6);
        push_byte(CH_CR);
        push_byte(CH_LF);
        close_body(0);
        send_body();

        // prefixed size with extension, body ends inside the trailer
        body_words.delete();
        push_byte(CH_0);
        push_byte(CH_UX);
        push_byte(CH_0 + 8'd1);
        push_byte(CH_SEMI);
        push_byte(8'h7A);
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_byte(8'h5A);
        push_byte(CH_CR);
        close_body(0);
        send_body();
        wait_drained();

        while (words_sent < ITEM_TARGET)
        begin
            calm = (words_sent > ITEM_TARGET * 85 / 100) || ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 60)
                kind = BODY_CLEAN;
            else if (pick < 72)
                kind = BODY_CUT;
            else if (pick < 78)
                kind = BODY_NEGATIVE;
            else if (pick < 84)
                kind = BODY_EARLY_EOL;
            else if (pick < 89)
                kind = BODY_BARE_PREFIX;
            else if (pick < 95)
                kind = BODY_OVERSIZE;
            else
                kind = BODY_NOISE;
            build_body(kind);
            send_body();
            if (!paused && words_sent > ITEM_TARGET / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d bodies in %0d body bytes: clean, truncated, negative, empty line,",
                 bodies_closed, words_sent);
        $display("bare prefix, oversized and noise framing; %0d payload words, %0d oversized",
                 payload_words, oversize_bodies);
        if (mismatch_count == 0 && results_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
